// ----- sv/tglc_pkg.sv -----
// Package for the tile grid line collision block.
// Holds channel payload types, operation and status codes, and sequencer states.
package tglc_pkg;

  localparam int CW  = 14;
  localparam int DW  = 13;
  localparam int DSW = 17;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_CHECK  = 2'd1,
    OP_TRACE  = 2'd2,
    OP_ESCAPE = 2'd3
  } op_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_LEFT  = 2'd1;
  localparam logic [1:0] STAT_START = 2'd2;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_REC_X  = 3'd2;
  localparam logic [2:0] CFG_REC_Y  = 3'd3;
  localparam logic [2:0] CFG_ESC    = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [11:0] start_x;
    logic signed [11:0] start_y;
    logic signed [11:0] end_x;
    logic signed [11:0] end_y;
    logic               blocked_in;
  } in_t;

  typedef struct packed {
    logic signed [11:0] out_x;
    logic signed [11:0] out_y;
    logic               hit;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ADDR,
    ST_READ,
    ST_EVAL,
    ST_STEP,
    ST_DONE
  } state_t;

endpackage

// ----- sv/tile_grid_line_collision.sv -----
// From input transfer to out_valid: a write goes through address, tile read and evaluate;
// check_line repeats address, read and evaluate per cell tested; trace_line and escape
// repeat address, read, evaluate and step. Longest 1024-wide walk is 1025 steps.
// Each cell costs an address multiply, a tile RAM read and an evaluate step.
// One item at a time; the next transfer can be taken in the same cycle that out_valid rises.
// Reset (rst, synchronous): config registers to defaults, sequencer idle; tile RAM kept.
module tile_grid_line_collision
  import tglc_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

  function automatic logic on_grid(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                                   input logic [SW-1:0] w, input logic [SW-1:0] h);
    return x >= 0 && y >= 0 && x < $signed({1'b0, w}) && y < $signed({1'b0, h});
  endfunction

  state_t state, state_next;

  logic [10:0] grid_width, grid_height;
  logic [9:0]  recover_x, recover_y, escape_limit;
  logic [SW-1:0] eff_w, eff_h;

  op_t                  op;
  logic                 blk;
  logic signed [CW-1:0] sx, sy, ex, ey, cx, cy, lx, ly;
  logic [DW-1:0]        adx, ady, dmaj, dmin, maxd;
  logic [DW:0]          idx;
  logic                 negx, negy, maj, probe, onflag;
  logic signed [DSW-1:0] desc;
  logic [CW-1:0]        accx, accy;
  logic [AW-1:0]        addr;
  out_t                 res;

  logic signed [CW-1:0] dx, dy;
  logic [DW-1:0]        adx_c, ady_c;
  logic                 s_on, zero_d, maj_eq, ram_q, ram_we;
  logic                 eval_fin, step_fin;
  logic [2*SW-1:0]      prod;
  logic signed [CW-1:0] stx, sty;
  logic [CW-1:0]        accx_s, accy_s;
  logic signed [DSW-1:0] desc_next;

  assign eff_w = (32'(grid_width) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(grid_width);
  assign eff_h = (32'(grid_height) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(grid_height);

  assign dx     = ex - sx;
  assign dy     = ey - sy;
  assign adx_c  = dx[CW-1] ? DW'(-dx) : DW'(dx);
  assign ady_c  = dy[CW-1] ? DW'(-dy) : DW'(dy);
  assign s_on   = on_grid(sx, sy, eff_w, eff_h);
  assign zero_d = (dx == '0) && (dy == '0);
  assign stx    = negx ? -CW'(1) : CW'(1);
  assign sty    = negy ? -CW'(1) : CW'(1);
  assign maj_eq = maj ? (cy == ey) : (cx == ex);
  assign prod   = (2*SW)'(eff_w) * (2*SW)'(cy[SW-1:0]);
  assign accx_s = accx + CW'(adx);
  assign accy_s = accy + CW'(ady);
  assign desc_next = desc + $signed(DSW'({dmin, 1'b0}))
                   - ((desc > 0) ? $signed(DSW'({dmaj, 1'b0})) : DSW'(0));
  assign ram_we = (state == ST_READ) && (op == OP_WRITE) && onflag;
  assign step_fin = (idx > (DW+1)'(maxd)) ||
                    ((op == OP_ESCAPE) && (idx > (DW+1)'(escape_limit)));

  always_comb begin
    unique case (op)
      OP_WRITE: eval_fin = 1'b1;
      OP_CHECK: eval_fin = !onflag || ram_q || maj_eq;
      OP_TRACE: eval_fin = !onflag || ram_q;
      default:  eval_fin = !onflag || !ram_q;
    endcase
  end

  tglc_ram #(.WIDTH(1), .DEPTH(MAX_SIDE * MAX_SIDE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr),
    .wdata (blk),
    .rdata (ram_q)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= 11'd1024;
      grid_height  <= 11'd1024;
      recover_x    <= 10'd500;
      recover_y    <= 10'd500;
      escape_limit <= 10'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  grid_width   <= cfg_data;
        CFG_HEIGHT: grid_height  <= cfg_data;
        CFG_REC_X:  recover_x    <= cfg_data[9:0];
        CFG_REC_Y:  recover_y    <= cfg_data[9:0];
        CFG_ESC:    escape_limit <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_START;
      end
      ST_START: begin
        unique case (op)
          OP_WRITE: state_next = ST_ADDR;
          OP_CHECK: state_next = (!s_on || zero_d) ? ST_DONE : ST_ADDR;
          OP_TRACE: state_next = ST_STEP;
          default:  state_next = ST_ADDR;
        endcase
      end
      ST_ADDR: state_next = ST_READ;
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        if (probe) begin
          state_next = (!onflag || !ram_q) ? ST_DONE : ST_STEP;
        end else if (eval_fin) begin
          state_next = ST_DONE;
        end else begin
          state_next = (op == OP_CHECK) ? ST_ADDR : ST_STEP;
        end
      end
      ST_STEP: state_next = step_fin ? ST_DONE : ST_ADDR;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op   <= op_t'(in_data.operation);
        blk  <= in_data.blocked_in;
        sx   <= CW'(in_data.start_x);
        sy   <= CW'(in_data.start_y);
        ex   <= CW'(in_data.end_x);
        ey   <= CW'(in_data.end_y);
      end
      ST_START: begin
        cx    <= sx;
        cy    <= sy;
        lx    <= sx;
        ly    <= sy;
        adx   <= adx_c;
        ady   <= ady_c;
        negx  <= dx[CW-1];
        negy  <= dy[CW-1];
        maxd  <= (adx_c > ady_c) ? adx_c : ady_c;
        accx  <= '0;
        accy  <= '0;
        idx   <= '0;
        probe <= (op == OP_ESCAPE);
        maj   <= !(adx_c >= ady_c);
        dmaj  <= (adx_c >= ady_c) ? adx_c : ady_c;
        dmin  <= (adx_c >= ady_c) ? ady_c : adx_c;
        desc  <= (adx_c >= ady_c)
               ? $signed(DSW'({ady_c, 2'b00})) - $signed(DSW'(adx_c))
               : $signed(DSW'({adx_c, 2'b00})) - $signed(DSW'(ady_c));
        if (op == OP_CHECK) begin
          if (!s_on) begin
            res <= '{out_x: 12'(recover_x), out_y: 12'(recover_y), hit: 1'b1,
                     status: STAT_START};
          end else if (zero_d) begin
            res <= '{out_x: sx[11:0], out_y: sy[11:0], hit: 1'b0, status: STAT_OK};
          end else if (adx_c >= ady_c) begin
            cx <= sx + (dx[CW-1] ? -CW'(1) : CW'(1));
          end else begin
            cy <= sy + (dy[CW-1] ? -CW'(1) : CW'(1));
          end
        end
      end
      ST_ADDR: begin
        addr   <= AW'(prod + (2*SW)'(cx[SW-1:0]));
        onflag <= on_grid(cx, cy, eff_w, eff_h);
      end
      ST_READ: begin
      end
      ST_EVAL: begin
        if (probe) begin
          probe <= 1'b0;
          if (!onflag) begin
            res <= '{out_x: sx[11:0], out_y: sy[11:0], hit: 1'b0, status: STAT_START};
          end else if (!ram_q) begin
            res <= '{out_x: sx[11:0], out_y: sy[11:0], hit: 1'b0, status: STAT_OK};
          end
        end else begin
          unique case (op)
            OP_WRITE: res <= '{out_x: sx[11:0], out_y: sy[11:0], hit: 1'b0,
                               status: onflag ? STAT_OK : STAT_START};
            OP_CHECK: begin
              if (!onflag || ram_q) begin
                res <= '{out_x: lx[11:0], out_y: ly[11:0], hit: 1'b1,
                         status: onflag ? STAT_OK : STAT_LEFT};
              end else if (maj_eq) begin
                res <= '{out_x: ex[11:0], out_y: ey[11:0], hit: 1'b0, status: STAT_OK};
              end else begin
                lx   <= cx;
                ly   <= cy;
                desc <= desc_next;
                if (maj) begin
                  cy <= cy + sty;
                  if (desc > 0) cx <= cx + stx;
                end else begin
                  cx <= cx + stx;
                  if (desc > 0) cy <= cy + sty;
                end
              end
            end
            OP_TRACE: begin
              if (!onflag) begin
                res <= '{out_x: lx[11:0], out_y: ly[11:0], hit: 1'b1,
                         status: (idx == '0) ? STAT_START : STAT_LEFT};
              end else if (ram_q) begin
                res <= '{out_x: lx[11:0], out_y: ly[11:0], hit: 1'b1, status: STAT_OK};
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: begin
              if (!onflag) begin
                res <= '{out_x: lx[11:0], out_y: ly[11:0], hit: 1'b0, status: STAT_LEFT};
              end else if (!ram_q) begin
                res <= '{out_x: cx[11:0], out_y: cy[11:0], hit: 1'b1, status: STAT_OK};
              end else begin
                idx <= idx + 1'b1;
              end
            end
          endcase
        end
      end
      ST_STEP: begin
        if (idx > (DW+1)'(maxd)) begin
          if (op == OP_ESCAPE) begin
            res <= '{out_x: sx[11:0], out_y: sy[11:0], hit: 1'b0, status: STAT_OK};
          end else begin
            res <= '{out_x: ex[11:0], out_y: ey[11:0], hit: 1'b0, status: STAT_OK};
          end
        end else if (step_fin) begin
          res <= '{out_x: cx[11:0], out_y: cy[11:0], hit: 1'b0, status: STAT_OK};
        end else begin
          lx <= cx;
          ly <= cy;
          if (accx_s > CW'(maxd)) begin
            accx <= accx_s - CW'(maxd);
            cx   <= cx + stx;
          end else begin
            accx <= accx_s;
          end
          if (accy_s > CW'(maxd)) begin
            accy <= accy_s - CW'(maxd);
            cy   <= cy + sty;
          end else begin
            accy <= accy_s;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_data <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> $past(state) == ST_READ)
    else $error("evaluate step without a tile read");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_START)
    else $error("accepted transfer did not start the sequencer");
  a_write_only_on_grid: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> op == OP_WRITE && onflag && $past(state) == ST_ADDR)
    else $error("tile write outside a write item");
  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && (!out_valid || out_ready) |=> out_valid && state == ST_IDLE)
    else $error("finished result not moved to output");
`endif

endmodule

// ----- sv/tglc_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module tglc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
